// File: hdl/spmq_pkg.sv
package spmq_pkg;

	// Command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// Priority levels
	localparam logic [1:0] LVL_NORMAL = 2'd0;
	localparam logic [1:0] LVL_HIGH   = 2'd1;
	localparam logic [1:0] LVL_ULTRA  = 2'd2;

	localparam int MSG_W   = 64;
	localparam int LVL_W   = 2;
	localparam int COUNT_W = 5;

	// Request and result payloads
	typedef struct packed {
		logic             cmd;
		logic [MSG_W-1:0] message;
		logic [LVL_W-1:0] level;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [MSG_W-1:0]   head_message;
		logic [LVL_W-1:0]   head_level;
		logic [COUNT_W-1:0] count;
	} res_t;

	// One stored entry
	typedef struct packed {
		logic [MSG_W-1:0] message;
		logic [LVL_W-1:0] level;
	} entry_t;

	// Broadcast control to every cell
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t item;
	} cell_ctrl_t;

endpackage

// File: hdl/spmq_cell.sv
module spmq_cell import spmq_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occupied,
	input  logic       left_stay,
	input  entry_t     left_entry,
	input  entry_t     right_entry,
	output entry_t     entry,
	output logic       stay
);

	entry_t entry_q;

	// Hold while the stored entry ranks equal or above the new one
	assign stay  = occupied && (entry_q.level >= ctrl.item.level);
	assign entry = entry_q;

	// Insert, shift towards the tail on push, shift towards the head on pop
	always_ff @(posedge clk) begin
		if (ctrl.push && !stay) begin
			entry_q <= left_stay ? ctrl.item : left_entry;
		end else if (ctrl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

// File: hdl/stable_priority_message_queue.sv
// Stable priority queue of fixed-length messages, up to DEPTH entries.
// Request channel (req_valid, req_stall, req): cmd selects push or pop.
// A push stores message and level (level 3 is taken as 2) behind every
// entry of equal or higher level; a full queue refuses it with ok = 0.
// A pop returns the head entry; an empty queue returns ok = 0 and zeros.
// Result channel (res_valid, res_stall, res): one result per request,
// carrying ok, the popped message and level, and the count afterwards.
// The result is registered and appears in the cycle after the request
// is taken. Throughput: one request per cycle, set by the row of entry
// cells which compare and shift all in the same cycle, but for stalls:
// while a result waits under res_stall, req_stall is raised and the
// next request is held off until the result is taken.
// Reset clears the entry count and the result valid; entry contents are
// not cleared, only cells below the count are ever read.
module stable_priority_message_queue import spmq_pkg::*; #(
	parameter int DEPTH         = 16,
	parameter int MESSAGE_CHARS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [MSG_W-1:0] MSG_MASK = {MSG_W{1'b1}} >> (MSG_W - 8 * MESSAGE_CHARS);

	logic          res_valid_q;
	res_t          res_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          req_take;
	logic          full;
	logic          empty;
	logic          push_ok;
	logic          pop_ok;
	cell_ctrl_t    ctrl;
	entry_t        entries [DEPTH];
	logic [DEPTH-1:0] stays;
	logic [DEPTH-1:0] occupied;

	assign req_stall = res_valid_q && res_stall;
	assign req_take  = req_valid && !req_stall;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign push_ok   = req_take && (req.cmd == CMD_PUSH) && !full;
	assign pop_ok    = req_take && (req.cmd == CMD_POP) && !empty;

	// Build the broadcast item: drop unused bytes, saturate the level
	always_comb begin
		ctrl.push         = push_ok;
		ctrl.pop          = pop_ok;
		ctrl.item.message = req.message & MSG_MASK;
		ctrl.item.level   = (req.level > LVL_ULTRA) ? LVL_ULTRA : req.level;
	end

	// Row of entry cells, head at index 0
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			assign occupied[gi] = (count_q > CW'(gi));
			spmq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occupied    (occupied[gi]),
				.left_stay   ((gi == 0) ? 1'b1 : stays[(gi == 0) ? 0 : gi - 1]),
				.left_entry  (entries[(gi == 0) ? 0 : gi - 1]),
				.right_entry (entries[(gi == DEPTH - 1) ? gi : gi + 1]),
				.entry       (entries[gi]),
				.stay        (stays[gi])
			);
		end
	endgenerate

	// Advance the entry count
	always_comb begin
		count_d = count_q;
		if (push_ok) begin
			count_d = count_q + CW'(1);
		end else if (pop_ok) begin
			count_d = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// Result valid: set on a taken request, drop once delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (req_take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (req_take) begin
			res_q.ok           <= push_ok || pop_ok;
			res_q.head_message <= pop_ok ? entries[0].message : '0;
			res_q.head_level   <= pop_ok ? entries[0].level : LVL_NORMAL;
			res_q.count        <= COUNT_W'(count_d);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Count stays within the row
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// A push on a queue with room grows the count by one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && (req.cmd == CMD_PUSH) && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not grow count");

	// A pop on an empty queue reports failure with zero payload
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && (req.cmd == CMD_POP) && empty |=>
		!res_q.ok && (res_q.head_message == '0) && (res_q.head_level == LVL_NORMAL))
		else $error("pop on empty queue returned data");

	// Popped level is always a legal level
	a_head_level: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_q.head_level != 2'd3)
		else $error("illegal head level");

	// A stalled result blocks new requests
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_stall |-> req_stall)
		else $error("request taken over a stalled result");

endmodule
